// File: hw/rtl/urc_pkg.sv
// Shared types and constants of the ultrasonic ranging controller.
package urc_pkg;

  localparam int unsigned US_PER_MS = 1000;

  localparam int unsigned PRE_W   = 10;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned IVAL_W  = 15;
  localparam int unsigned WIDTH_W = 10;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned PROD_W  = COUNT_W + SPEED_W;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CDATA_W = 16;

  localparam logic [MS_W-1:0]    MS_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  // count * speed / 2000 = ((count * speed) >> 4) / 125
  // x / 125 = (x * RECIP_125) >> RECIP_SHIFT, exact for x below 2^26
  localparam int unsigned DIV_IN_W    = PROD_W - 4;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_125 = 27'd68719477;
  localparam int unsigned SCALED_W    = DIV_IN_W + RECIP_W;
  localparam int unsigned QUOT_W      = SCALED_W - RECIP_SHIFT;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TRIG_INTERVAL = 8'd0;
  localparam logic [IDX_W-1:0] REG_ECHO_TIMEOUT  = 8'd1;
  localparam logic [IDX_W-1:0] REG_TRIG_WIDTH    = 8'd2;
  localparam logic [IDX_W-1:0] REG_SOUND_SPEED   = 8'd3;

  localparam logic [IVAL_W-1:0]  RST_TRIG_INTERVAL = 15'd200;
  localparam logic [IVAL_W-1:0]  RST_ECHO_TIMEOUT  = 15'd30;
  localparam logic [WIDTH_W-1:0] RST_TRIG_WIDTH    = 10'd15;
  localparam logic [SPEED_W-1:0] RST_SOUND_SPEED   = 10'd343;

  typedef enum logic [1:0] {
    DIST_KEEP,
    DIST_LOAD,
    DIST_CLEAR
  } dist_op_e;

  typedef struct packed {
    logic [IVAL_W-1:0]  trig_interval;
    logic [IVAL_W-1:0]  echo_timeout;
    logic [WIDTH_W-1:0] trig_width;
    logic [SPEED_W-1:0] sound_speed;
  } cfg_t;

  typedef struct packed {
    logic trig;
    logic measuring;
    logic ready;
    logic timed_out;
    dist_op_e op;
  } flags_t;

  // control stage result handed to the distance pipeline
  typedef struct packed {
    flags_t             flags;
    logic [COUNT_W-1:0] count;
    logic [SPEED_W-1:0] speed;
  } tick_t;

  typedef struct packed {
    flags_t            flags;
    logic [PROD_W-1:0] prod;
  } prod_t;

  typedef struct packed {
    logic              trig;
    logic [DIST_W-1:0] distance;
    logic              measuring;
    logic              ready;
    logic              timed_out;
  } result_t;

endpackage

// File: hw/rtl/urc_ctrl.sv
// Per-tick control: echo edge timing, millisecond timebase, timeout and trigger.
module urc_ctrl import urc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  logic  echo_i,
  input  cfg_t  cfg_i,
  output tick_t tick_o
);

  logic [PRE_W-1:0]   pre_q, pre_d;
  logic [MS_W-1:0]    ms_q, ms_d;
  logic               await_q, await_d;
  logic               active_q, active_d;
  logic               prev_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [WIDTH_W-1:0] trem_q, trem_d;
  tick_t              tick_q, tick_d;

  logic [PRE_W:0] pre_inc;
  logic           boundary;

  assign pre_inc  = {1'b0, pre_q} + 1'b1;
  assign boundary = pre_inc >= (PRE_W+1)'(US_PER_MS);

  always_comb begin
    pre_d    = pre_q;
    ms_d     = ms_q;
    await_d  = await_q;
    active_d = active_q;
    count_d  = count_q;
    trem_d   = trem_q;
    tick_d.flags.ready     = 1'b0;
    tick_d.flags.timed_out = 1'b0;
    tick_d.flags.op        = DIST_KEEP;
    tick_d.count           = count_q;
    tick_d.speed           = cfg_i.sound_speed;

    // each echo edge starts or stops the pulse counter
    if (echo_i != prev_q) begin
      if (!active_q) begin
        active_d = 1'b1;
        count_d  = '0;
      end else begin
        active_d           = 1'b0;
        tick_d.flags.ready = 1'b1;
        tick_d.flags.op    = DIST_LOAD;
      end
    end else if (active_q && count_q != COUNT_MAX) begin
      count_d = count_q + 1'b1;
    end

    if (boundary) begin
      pre_d = '0;
      if (ms_q != MS_MAX) ms_d = ms_q + 1'b1;
      if (await_q) begin
        if (!active_d) begin
          await_d = 1'b0;
        end else if (ms_d > {1'b0, cfg_i.echo_timeout}) begin
          active_d               = 1'b0;
          await_d                = 1'b0;
          tick_d.flags.ready     = 1'b1;
          tick_d.flags.timed_out = 1'b1;
          tick_d.flags.op        = DIST_CLEAR;
        end
      end
      if (!await_d && ms_d >= {1'b0, cfg_i.trig_interval}) begin
        trem_d  = cfg_i.trig_width;
        ms_d    = '0;
        await_d = 1'b1;
      end
    end else begin
      pre_d = pre_inc[PRE_W-1:0];
    end

    tick_d.flags.trig = trem_d != '0;
    if (tick_d.flags.trig) trem_d = trem_d - 1'b1;
    tick_d.flags.measuring = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q    <= '0;
      ms_q     <= '0;
      await_q  <= 1'b0;
      active_q <= 1'b0;
      prev_q   <= 1'b0;
      count_q  <= '0;
      trem_q   <= '0;
    end else if (accept_i) begin
      pre_q    <= pre_d;
      ms_q     <= ms_d;
      await_q  <= await_d;
      active_q <= active_d;
      prev_q   <= echo_i;
      count_q  <= count_d;
      trem_q   <= trem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) tick_q <= tick_d;
  end

  assign tick_o = tick_q;

endmodule

// File: hw/rtl/urc_dist.sv
// Distance pipeline: pulse length times speed, divide by 2000, saturate, hold.
module urc_dist import urc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_prod_i,
  input  logic    load_out_i,
  input  tick_t   tick_i,
  output result_t result_o
);

  prod_t              prod_q;
  logic [DIV_IN_W-1:0] div_in;
  logic [SCALED_W-1:0] scaled;
  logic [QUOT_W-1:0]   quot;
  logic [DIST_W-1:0]   dist_sat;
  logic [DIST_W-1:0]   dist_q, dist_d;
  flags_t              flags_q;

  always_ff @(posedge clk_i) begin
    if (load_prod_i) begin
      prod_q.flags <= tick_i.flags;
      prod_q.prod  <= {{SPEED_W{1'b0}}, tick_i.count} * {{COUNT_W{1'b0}}, tick_i.speed};
    end
  end

  assign div_in   = prod_q.prod[PROD_W-1:4];
  assign scaled   = {{RECIP_W{1'b0}}, div_in} * {{DIV_IN_W{1'b0}}, RECIP_125};
  assign quot     = scaled[SCALED_W-1:RECIP_SHIFT];
  assign dist_sat = (quot > QUOT_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];

  always_comb begin
    case (prod_q.flags.op)
      DIST_LOAD:  dist_d = dist_sat;
      DIST_CLEAR: dist_d = '0;
      default:    dist_d = dist_q;
    endcase
  end

  // the output distance register doubles as the stored distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (load_out_i) begin
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_i) flags_q <= prod_q.flags;
  end

  assign result_o.trig      = flags_q.trig;
  assign result_o.distance  = dist_q;
  assign result_o.measuring = flags_q.measuring;
  assign result_o.ready     = flags_q.ready;
  assign result_o.timed_out = flags_q.timed_out;

endmodule

// File: hw/rtl/ultrasonic_ranging_controller.sv
// Ultrasonic ranging controller top level: config registers, stream ports, pipeline.
// A tick request passes the control, product and output registers to the master side.
// Throughput: one tick per cycle while unstalled; three stages: control, product, output.
// A stalled master side backs up stage by stage; bubbles still let requests in.
// Reset (rst_ni low, asynchronous): timebase, echo timing, trigger and distance clear
// to zero, config registers return to 200 ms / 30 ms / 15 us / 343 m/s.
module ultrasonic_ranging_controller import urc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tick requests; tdata: [0] echo_level, [7:1] zero
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  // results; tdata: [0] trigger_level, [16:1] distance_mm, [17] measuring,
  // [18] result_ready, [19] timed_out, [23:20] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [CDATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  tick_t   tick;
  result_t result;

  // stage valid bits: control, product, output
  logic ctl_vld_q, prod_vld_q, out_vld_q;
  logic ctl_rdy, prod_rdy, out_rdy;
  logic accept;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_interval <= RST_TRIG_INTERVAL;
      cfg_q.echo_timeout  <= RST_ECHO_TIMEOUT;
      cfg_q.trig_width    <= RST_TRIG_WIDTH;
      cfg_q.sound_speed   <= RST_SOUND_SPEED;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TRIG_INTERVAL: cfg_q.trig_interval <= cfg_data_i[IVAL_W-1:0];
        REG_ECHO_TIMEOUT:  cfg_q.echo_timeout  <= cfg_data_i[IVAL_W-1:0];
        REG_TRIG_WIDTH:    cfg_q.trig_width    <= cfg_data_i[WIDTH_W-1:0];
        REG_SOUND_SPEED:   cfg_q.sound_speed   <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage can take new data when empty or when its content moves on.
  assign out_rdy  = !out_vld_q || m_axis_tready;
  assign prod_rdy = !prod_vld_q || out_rdy;
  assign ctl_rdy  = !ctl_vld_q || prod_rdy;

  assign s_axis_tready = ctl_rdy;
  assign accept        = s_axis_tvalid && ctl_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (ctl_rdy)  ctl_vld_q  <= s_axis_tvalid;
      if (prod_rdy) prod_vld_q <= ctl_vld_q;
      if (out_rdy)  out_vld_q  <= prod_vld_q;
    end
  end

  urc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .echo_i   (s_axis_tdata[0]),
    .cfg_i    (cfg_q),
    .tick_o   (tick)
  );

  // The stored distance only changes when a real tick reaches the output stage.
  urc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_prod_i (ctl_vld_q && prod_rdy),
    .load_out_i  (prod_vld_q && out_rdy),
    .tick_i      (tick),
    .result_o    (result)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, result.timed_out, result.ready, result.measuring,
                          result.distance, result.trig};

endmodule

// File: dv/tb_ultrasonic_ranging_controller.sv
// Testbench for the ultrasonic ranging controller: tick stream vs. a cycle-free predictor.
module tb_ultrasonic_ranging_controller;
  import urc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS = 40;

  // one result request, packed in the same bit order as m_axis_tdata[19:0]
  typedef struct packed {
    logic              timed_out;
    logic              ready;
    logic              measuring;
    logic [DIST_W-1:0] distance_mm;
    logic              trig;
  } tick_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IDX_W-1:0]   cfg_index_i = '0;
  logic [CDATA_W-1:0] cfg_data_i = '0;

  ultrasonic_ranging_controller u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: timebase, echo timing, trigger and the live registers
  // ---------------------------------------------------------------------------
  cfg_t               live_cfg;
  logic [PRE_W-1:0]   tick_in_ms;
  logic [MS_W-1:0]    ms_since_ping;
  logic               ping_armed;
  logic               echo_timing;
  logic               echo_last;
  logic [COUNT_W-1:0] echo_ticks;
  logic [WIDTH_W-1:0] trig_left;
  logic [DIST_W-1:0]  range_mm;
  int unsigned        pings_fired;
  int unsigned        timeouts_seen;

  tick_result_t expected_ticks[$];
  int unsigned  mismatches;
  int unsigned  ticks_sent;

  // stimulus shaping
  bit          stream_on;
  bit          gaps_on;
  int unsigned burst_left;
  bit          rx_open;
  int unsigned rx_hold_req;

  function automatic void clear_model();
    live_cfg.trig_interval = RST_TRIG_INTERVAL;
    live_cfg.echo_timeout  = RST_ECHO_TIMEOUT;
    live_cfg.trig_width    = RST_TRIG_WIDTH;
    live_cfg.sound_speed   = RST_SOUND_SPEED;
    tick_in_ms    = '0;
    ms_since_ping = '0;
    ping_armed    = 1'b0;
    echo_timing   = 1'b0;
    echo_last     = 1'b0;
    echo_ticks    = '0;
    trig_left     = '0;
    range_mm      = '0;
  endfunction

  // Advance one microsecond tick and return what the block must show for it.
  function automatic tick_result_t step_ranging(input logic echo);
    tick_result_t res;
    int unsigned  mm;
    res = '0;
    // any edge toggles between starting and stopping the pulse timer
    if (echo != echo_last) begin
      if (!echo_timing) begin
        echo_timing = 1'b1;
        echo_ticks  = '0;
      end else begin
        mm = (int'(echo_ticks) * int'(live_cfg.sound_speed)) / 2000;
        range_mm    = (mm > int'(DIST_MAX)) ? DIST_MAX : mm[DIST_W-1:0];
        echo_timing = 1'b0;
        res.ready   = 1'b1;
      end
    end else if (echo_timing && echo_ticks != COUNT_MAX) begin
      echo_ticks++;
    end
    echo_last = echo;

    if (int'(tick_in_ms) + 1 >= US_PER_MS) begin
      tick_in_ms = '0;
      if (ms_since_ping != MS_MAX) ms_since_ping++;
      if (ping_armed) begin
        if (!echo_timing) begin
          ping_armed = 1'b0;
        end else if (ms_since_ping > live_cfg.echo_timeout) begin
          // abandoned echo; a stop edge on this same tick already cleared timing
          echo_timing   = 1'b0;
          range_mm      = '0;
          ping_armed    = 1'b0;
          res.ready     = 1'b1;
          res.timed_out = 1'b1;
          timeouts_seen++;
        end
      end
      if (!ping_armed && ms_since_ping >= live_cfg.trig_interval) begin
        trig_left     = live_cfg.trig_width;
        ms_since_ping = '0;
        ping_armed    = 1'b1;
        pings_fired++;
      end
    end else begin
      tick_in_ms++;
    end

    res.trig = (trig_left != '0);
    if (res.trig) trig_left--;
    res.distance_mm = range_mm;
    res.measuring   = echo_timing;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern, long hold-off on request, and the checker
  // ---------------------------------------------------------------------------
  int unsigned rx_hold_left;
  int unsigned rx_run_left;
  bit          rx_stalling;

  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_open) begin
      m_axis_tready <= 1'b1;
    end else begin
      // alternating runs of ready and stall, lengths drawn fresh each run
      if (rx_run_left == 0) begin
        rx_stalling = !rx_stalling;
        rx_run_left = rx_stalling ? $urandom_range(1, 9) : $urandom_range(1, 20);
      end
      rx_run_left--;
      m_axis_tready <= !rx_stalling;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    tick_result_t want;
    tick_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = tick_result_t'(m_axis_tdata[19:0]);
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_ticks.pop_front();
        check_field("trigger_level", want.trig, got.trig);
        check_field("distance_mm", want.distance_mm, got.distance_mm);
        check_field("measuring", want.measuring, got.measuring);
        check_field("result_ready", want.ready, got.ready);
        check_field("timed_out", want.timed_out, got.timed_out);
        check_field("tdata pad", 0, m_axis_tdata[23:20]);
      end
    end
  end

  // watchdog: any handshake on any channel restarts the count
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic echo);
    int unsigned idle;
    idle = stream_on ? 0 : 1;
    if (gaps_on && burst_left == 0) begin
      idle       = $urandom_range(1, 7);
      burst_left = $urandom_range(1, 32);
    end
    if (idle != 0) begin
      if (stream_on) s_axis_tvalid <= 1'b0;
      stream_on = 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, echo};
    stream_on = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left != 0) burst_left--;
    ticks_sent++;
    expected_ticks.push_back(step_ranging(echo));
  endtask

  task automatic wait_results_drained();
    if (stream_on) s_axis_tvalid <= 1'b0;
    stream_on = 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TRIG_INTERVAL: live_cfg.trig_interval = data[IVAL_W-1:0];
      REG_ECHO_TIMEOUT:  live_cfg.echo_timeout  = data[IVAL_W-1:0];
      REG_TRIG_WIDTH:    live_cfg.trig_width    = data[WIDTH_W-1:0];
      REG_SOUND_SPEED:   live_cfg.sound_speed   = data[SPEED_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper data bits carry noise; the block must mask them off
  task automatic set_timing(input int unsigned interval, input int unsigned timeout,
                            input int unsigned width, input int unsigned speed);
    write_reg(REG_TRIG_INTERVAL, {1'($urandom), IVAL_W'(interval)});
    write_reg(REG_ECHO_TIMEOUT, {1'($urandom), IVAL_W'(timeout)});
    write_reg(REG_TRIG_WIDTH, {6'($urandom), WIDTH_W'(width)});
    write_reg(REG_SOUND_SPEED, {6'($urandom), SPEED_W'(speed)});
  endtask

  // closes any open timing, then a start edge, hold_ticks steady ticks, stop edge
  task automatic echo_pulse(input int unsigned hold_ticks);
    logic lvl;
    if (echo_timing) send_tick(!echo_last);
    lvl = !echo_last;
    repeat (hold_ticks + 1) send_tick(lvl);
    send_tick(!lvl);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // A millisecond boundary falls on every thousandth tick, so the tests are
  // ordered: the zero-width test waits for a boundary to fire its ping, the
  // timeout test waits for one to abandon an echo that is still open.
  task automatic test_reset_defaults();
    // edges with no trigger pending still time pulses, at the reset speed
    repeat (3) send_tick(1'b0);
    echo_pulse(0);
    echo_pulse(1);
    echo_pulse(9);
    send_tick(1'b1);
    send_tick(1'b0);
    echo_pulse(12);
  endtask

  task automatic test_register_writes();
    int unsigned speeds[4] = '{0, 1023, 1, 343};
    foreach (speeds[i]) begin
      write_reg(REG_SOUND_SPEED, {6'($urandom), SPEED_W'(speeds[i])});
      echo_pulse(40);
      echo_pulse(3);
    end
    // writes to indexes with no register behind them change nothing
    write_reg(IDX_W'($urandom_range(4, 254)), CDATA_W'($urandom));
    write_reg(IDX_W'(255), CDATA_W'($urandom));
    write_reg(IDX_W'(4), 16'hFFFF);
    echo_pulse(40);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_open = 1'b0;
    set_timing(32767, 1, 8, 500);
    rx_hold_req = 400;
    repeat (200) send_tick(1'($urandom));
    repeat (20) send_tick(echo_last);
  endtask

  task automatic random_echo_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned kind;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // well-formed: quiet stretch, then a clean echo pulse
        repeat ($urandom_range(1, 30)) send_tick(echo_last);
        echo_pulse($urandom_range(0, 100));
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom));
      end else begin
        // broken: an edge and a long steady level
        send_tick(!echo_last);
        repeat ($urandom_range(20, 80)) send_tick(echo_last);
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      gaps_on = (phase != 1);
      rx_open = 1'b0;
      case (phase)
        0: set_timing(32767, 32767, 1, 1023);
        1: set_timing(32767, 32767, 1023, 0);
        default: set_timing(32767, 32767, $urandom_range(1, 1023), $urandom_range(0, 1023));
      endcase
      random_echo_traffic(100);
    end
  endtask

  task automatic test_zero_width_ping();
    int unsigned fired;
    gaps_on = 1'b0;
    rx_open = 1'b0;
    // zero width: no trigger pulse, but the measurement window still opens
    set_timing(1, 0, 0, 343);
    fired = pings_fired;
    if (echo_timing) send_tick(!echo_last);
    while (pings_fired == fired) send_tick(echo_last);
    echo_pulse(60);
    echo_pulse(5);
  endtask

  task automatic test_long_echo();
    gaps_on = 1'b0;
    rx_open = 1'b1;
    // long pulse at full speed: a long count times the largest speed value
    write_reg(REG_SOUND_SPEED, SPEED_W'(1023));
    echo_pulse(600);
    repeat (10) send_tick(echo_last);
    rx_open = 1'b0;
  endtask

  task automatic test_echo_timeout();
    int unsigned seen;
    gaps_on = 1'b1;
    rx_open = 1'b0;
    set_timing(1, 0, 20, $urandom_range(1, 1023));
    // open an echo and never close it: abandoned at the next boundary,
    // which also fires a fresh trigger pulse
    seen = timeouts_seen;
    if (!echo_timing) send_tick(!echo_last);
    while (timeouts_seen == seen) send_tick(echo_last);
    repeat (30) send_tick(echo_last);
    echo_pulse(5);
  endtask

  initial begin
    clear_model();
    mismatches    = 0;
    ticks_sent    = 0;
    pings_fired   = 0;
    timeouts_seen = 0;
    stream_on     = 1'b0;
    gaps_on       = 1'b1;
    burst_left    = 0;
    rx_open       = 1'b0;
    rx_hold_req   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_writes();
    test_backpressure();
    test_random_traffic();
    test_zero_width_ping();
    test_long_echo();
    test_echo_timeout();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/urc_pkg.sv
hw/rtl/urc_ctrl.sv
hw/rtl/urc_dist.sv
hw/rtl/ultrasonic_ranging_controller.sv
dv/tb_ultrasonic_ranging_controller.sv
